@@ rtl/assert_macros.svh @@
// Assertion helpers for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define U2U_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked during reset.
`define U2U_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/u2u_pkg.sv @@
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u2u_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PendW   = 2;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [StatusW-1:0] ST_TRUNC    = 2'd2;

  typedef struct packed {
    logic [UnitW-1:0]   code_unit;
    logic [StatusW-1:0] status;
    logic               final_unit;
  } u2u_result_t;

endpackage

`default_nettype wire

@@ rtl/u2u_decode.sv @@
// ----------------------------------------------------------------------------
// u2u_decode
// Per-byte decode: sequence state registers and the result it yields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u2u_decode
  import u2u_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [ByteW-1:0]  byte_in,
  input  wire logic              last_in,
  output logic                   res_valid,
  output u2u_result_t            res
);

  logic [PendW-1:0] pending_r, pending_nxt;
  logic [UnitW-1:0] partial_r, partial_nxt;
  logic [UnitW-1:0] cont_bits;
  logic [UnitW-1:0] merged;
  logic             has_res;

  always_comb begin
    cont_bits = {{(UnitW-6){1'b0}}, byte_in[5:0]};
    case (pending_r)
      2'd1:    merged = partial_r | cont_bits;
      2'd2:    merged = partial_r | (cont_bits << 6);
      default: merged = partial_r | (cont_bits << 12);
    endcase
  end

  always_comb begin
    pending_nxt    = pending_r;
    partial_nxt    = partial_r;
    has_res        = 1'b0;
    res.code_unit  = '0;
    res.status     = ST_OK;
    res.final_unit = last_in;
    if (pending_r != '0) begin
      pending_nxt = pending_r - 2'd1;
      partial_nxt = merged;
      if (pending_r == 2'd1) begin
        partial_nxt   = '0;
        has_res       = 1'b1;
        res.code_unit = merged;
      end
    end else if (!byte_in[7] || byte_in[7:6] == 2'b10) begin
      has_res       = 1'b1;
      res.code_unit = {{(UnitW-ByteW){1'b0}}, byte_in};
    end else if (byte_in[7:4] == 4'b1110) begin
      pending_nxt = 2'd2;
      partial_nxt = {byte_in[3:0], 12'd0};
    end else if (byte_in[7:5] == 3'b110) begin
      pending_nxt = 2'd1;
      partial_nxt = {5'd0, byte_in[4:0], 6'd0};
    end else begin
      pending_nxt = '0;
      partial_nxt = '0;
      has_res     = 1'b1;
      res.status  = ST_BAD_LEAD;
    end
    if (!has_res && last_in) begin
      pending_nxt = '0;
      partial_nxt = '0;
      has_res     = 1'b1;
      res.status  = ST_TRUNC;
    end
  end

  assign res_valid = step && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      partial_r <= '0;
    end else if (step) begin
      pending_r <= pending_nxt;
      partial_r <= partial_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/u2u_out_buf.sv @@
// ----------------------------------------------------------------------------
// u2u_out_buf
// Result register with a skid stage; full flag needs no path from tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u2u_out_buf
  import u2u_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire u2u_result_t  push_data,
  output logic              full,
  output logic              out_valid,
  input  wire logic         out_ready,
  output u2u_result_t       out_data
);

  logic        main_valid_r, main_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  u2u_result_t main_r, main_nxt;
  u2u_result_t skid_r, skid_nxt;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    if (!main_valid_r || out_ready) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_nxt       = skid_r;
        skid_valid_nxt = push;
        skid_nxt       = push_data;
      end else begin
        main_valid_nxt = push;
        main_nxt       = push_data;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_nxt       = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

`default_nettype wire

@@ rtl/utf8_to_utf16_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder
// UTF-8 byte stream in, 16-bit code units out (2- and 3-byte sequences).
// ----------------------------------------------------------------------------
// Input channel: one byte per item on in_tdata, in_tlast on the final byte
// of a string. Output channel: a code unit on out_tdata, status on out_tuser
// (ok, unsupported lead, truncated at end), out_tlast when it closes the
// string. Lead bytes and mid-sequence continuation bytes give no item; a
// completed character or an error gives one.
// Path: accepting a byte loads it into the input register; the decoded
// result of the last byte of a character then goes into the result register,
// or into the skid slot when the receiver stalls.
// Throughput: one byte per cycle while the skid slot is empty, set by the single decode stage.
// Reset clears the sequence state and the valid flags of the input register and both result slots.
// When the receiver stalls, the result register holds and one more result
// goes into the skid slot; the input register still takes one more byte,
// after which in_tready falls until the skid slot drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utf8_to_utf16_stream_decoder
  import u2u_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [ByteW-1:0]   in_tdata,   // [7:0] in_byte
  input  wire logic               in_tlast,   // end_of_string
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [UnitW-1:0]        out_tdata,  // [15:0] code_unit
  output logic [StatusW-1:0]      out_tuser,  // [1:0] status
  output logic                    out_tlast   // final_unit
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [ByteW-1:0] s1_byte_r;
  logic             s1_last_r;
  logic             in_accept;
  logic             advance;
  logic             buf_full;
  logic             res_valid;
  u2u_result_t      res;
  u2u_result_t      out_res;

  assign in_tready = !s1_valid_r || !buf_full;
  assign in_accept = in_tvalid && in_tready;
  assign advance   = s1_valid_r && !buf_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  u2u_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .byte_in   (s1_byte_r),
    .last_in   (s1_last_r),
    .res_valid (res_valid),
    .res       (res)
  );

  u2u_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (buf_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = out_res.code_unit;
  assign out_tuser = out_res.status;
  assign out_tlast = out_res.final_unit;

  `U2U_ASSERT_IMP(a_err_zero, out_tvalid && out_tuser != ST_OK, out_tdata == '0,
                  "error item with nonzero code unit")
  `U2U_ASSERT_IMP(a_trunc_last, out_tvalid && out_tuser == ST_TRUNC, out_tlast,
                  "truncation item not final")
  `U2U_ASSERT_IMP(a_skid_main, buf_full, out_tvalid,
                  "skid slot full with result register empty")
  `U2U_ASSERT_NXT(a_full_hold, buf_full, out_tvalid,
                  "result lost after skid slot filled")

endmodule

`default_nettype wire
